/* hdl/scpf_pkg.sv */
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types and constants for the semicolon command frame parser.
// ----------------------------------------------------------------------------
package scpf_pkg;

  // Width of the signed command values.
  localparam int VALUE_WIDTH = 16;
  // Accumulator width while a digit is folded in (times ten plus a digit).
  localparam int ACC_WIDTH   = VALUE_WIDTH + 4;

  // Largest magnitude kept (the most negative value) and largest positive value.
  localparam logic [VALUE_WIDTH-1:0] MAG_LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] MAG_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // Characters of interest.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // Number scanning phases.
  localparam logic [1:0] PH_BLANKS = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // Token positions within a frame.
  localparam logic [2:0] TOK_NONE  = 3'd0;
  localparam logic [2:0] TOK_ACK   = 3'd1;
  localparam logic [2:0] TOK_SERVO = 3'd2;
  localparam logic [2:0] TOK_MOTOR = 3'd3;
  localparam logic [2:0] TOK_LIGHT = 3'd4;
  localparam logic [2:0] TOK_CTRL  = 3'd5;
  localparam logic [2:0] TOK_EXTRA = 3'd6;

  // Keyword match progress.
  localparam logic [2:0] ACK_DONE = 3'd3;
  localparam logic [2:0] ACK_FAIL = 3'd4;
  localparam logic [1:0] ONE_NONE = 2'd0;
  localparam logic [1:0] ONE_SEEN = 2'd1;
  localparam logic [1:0] ONE_FAIL = 2'd2;

  typedef struct packed {
    logic                   accepted;
    logic [VALUE_WIDTH-1:0] servo;
    logic [VALUE_WIDTH-1:0] motor;
    logic                   lights;
    logic                   control;
  } scpf_result_t;

  // Expected character at each position of the ACK keyword.
  function automatic logic [7:0] ack_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0:    ch = 8'h41;
      2'd1:    ch = 8'h43;
      2'd2:    ch = 8'h4B;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/scpf_core.sv */
// ----------------------------------------------------------------------------
// scpf_core
// Per-byte frame tokenizer and field decoder; holds the frame state and
// presents the finished result combinationally on a frame end step.
// ----------------------------------------------------------------------------
module scpf_core import scpf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   char_i,
  input  logic         end_i,
  output scpf_result_t result_o
);

  logic [2:0]             tok_idx_q, tok_idx_d;
  logic                   in_tok_q, in_tok_d;
  logic [2:0]             ack_prog_q, ack_prog_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [1:0]             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] servo_q, servo_d;
  logic [VALUE_WIDTH-1:0] motor_q, motor_d;
  logic [1:0]             one_prog_q, one_prog_d;
  logic [1:0]             flags_q, flags_d;
  logic                   ack_q, ack_d;
  logic                   ended_q, ended_d;

  logic [VALUE_WIDTH-1:0] num_val;
  logic                   fin_ack;
  logic [VALUE_WIDTH-1:0] fin_servo, fin_motor;
  logic [1:0]             fin_flags;

  logic [2:0]             cur_idx;
  logic [2:0]             cur_ack;
  logic [VALUE_WIDTH-1:0] cur_acc;
  logic [1:0]             cur_phase;
  logic                   cur_neg;
  logic [1:0]             cur_one;
  logic                   is_blank, is_digit, is_sign;
  logic [ACC_WIDTH-1:0]   acc_ext, acc_next;

  // Signed value of the token just scanned, saturated to the value range.
  always_comb begin
    if (neg_q) begin
      num_val = VALUE_WIDTH'(0) - acc_q;
    end else if (acc_q > MAG_MAX) begin
      num_val = MAG_MAX;
    end else begin
      num_val = acc_q;
    end
  end

  // Holds as they stand once an open token is closed.
  always_comb begin
    fin_ack   = ack_q;
    fin_servo = servo_q;
    fin_motor = motor_q;
    fin_flags = flags_q;
    if (in_tok_q) begin
      unique case (tok_idx_q)
        TOK_ACK:   fin_ack   = (ack_prog_q == ACK_DONE);
        TOK_SERVO: fin_servo = num_val;
        TOK_MOTOR: fin_motor = num_val;
        TOK_LIGHT: fin_flags[0] = fin_flags[0] | (one_prog_q == ONE_SEEN);
        TOK_CTRL:  fin_flags[1] = fin_flags[1] | (one_prog_q == ONE_SEEN);
        default:   ;
      endcase
    end
  end

  always_comb begin
    result_o.accepted = fin_ack;
    result_o.servo    = fin_ack ? fin_servo : '0;
    result_o.motor    = fin_ack ? fin_motor : '0;
    result_o.lights   = fin_ack & fin_flags[0];
    result_o.control  = fin_ack & fin_flags[1];
  end

  // A text byte outside a token opens a new one with fresh scan state.
  always_comb begin
    if (in_tok_q) begin
      cur_idx   = tok_idx_q;
      cur_ack   = ack_prog_q;
      cur_acc   = acc_q;
      cur_phase = phase_q;
      cur_neg   = neg_q;
      cur_one   = one_prog_q;
    end else begin
      cur_idx   = (tok_idx_q < TOK_EXTRA) ? tok_idx_q + 3'd1 : tok_idx_q;
      cur_ack   = 3'd0;
      cur_acc   = '0;
      cur_phase = PH_BLANKS;
      cur_neg   = 1'b0;
      cur_one   = ONE_NONE;
    end
  end

  assign is_blank = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_sign  = (char_i == CH_PLUS) || (char_i == CH_MINUS);
  assign acc_ext  = ACC_WIDTH'(cur_acc);
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_WIDTH'(char_i - CH_ZERO);

  always_comb begin
    tok_idx_d  = tok_idx_q;
    in_tok_d   = in_tok_q;
    ack_prog_d = ack_prog_q;
    acc_d      = acc_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    servo_d    = servo_q;
    motor_d    = motor_q;
    one_prog_d = one_prog_q;
    flags_d    = flags_q;
    ack_d      = ack_q;
    ended_d    = ended_q;

    if (step_i) begin
      priority if (end_i) begin
        // The frame is done: everything returns to its reset value.
        tok_idx_d  = TOK_NONE;
        in_tok_d   = 1'b0;
        ack_prog_d = 3'd0;
        acc_d      = '0;
        phase_d    = PH_BLANKS;
        neg_d      = 1'b0;
        servo_d    = '0;
        motor_d    = '0;
        one_prog_d = ONE_NONE;
        flags_d    = '0;
        ack_d      = 1'b0;
        ended_d    = 1'b0;
      end else if (ended_q) begin
        // Bytes after a NUL are ignored until the frame end.
      end else if (char_i == CH_NUL || char_i == CH_SEMI) begin
        in_tok_d = 1'b0;
        ack_d    = fin_ack;
        servo_d  = fin_servo;
        motor_d  = fin_motor;
        flags_d  = fin_flags;
        ended_d  = (char_i == CH_NUL);
      end else begin
        in_tok_d   = 1'b1;
        tok_idx_d  = cur_idx;
        ack_prog_d = cur_ack;
        acc_d      = cur_acc;
        phase_d    = cur_phase;
        neg_d      = cur_neg;
        one_prog_d = cur_one;
        unique case (cur_idx)
          TOK_ACK: begin
            if (cur_ack < ACK_DONE && char_i == ack_char(cur_ack[1:0])) begin
              ack_prog_d = cur_ack + 3'd1;
            end else begin
              ack_prog_d = ACK_FAIL;
            end
          end
          TOK_SERVO, TOK_MOTOR: begin
            priority if (cur_phase == PH_BLANKS && is_blank) begin
            end else if (cur_phase == PH_BLANKS && is_sign) begin
              neg_d   = (char_i == CH_MINUS);
              phase_d = PH_SIGNED;
            end else if (cur_phase != PH_STOP && is_digit) begin
              // The magnitude sticks at the limit once it passes it.
              acc_d   = (acc_next > ACC_WIDTH'(MAG_LIMIT)) ? MAG_LIMIT
                                                          : acc_next[VALUE_WIDTH-1:0];
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_STOP;
            end
          end
          TOK_LIGHT, TOK_CTRL: begin
            one_prog_d = (cur_one == ONE_NONE && char_i == CH_ONE) ? ONE_SEEN : ONE_FAIL;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q  <= TOK_NONE;
      in_tok_q   <= 1'b0;
      ack_prog_q <= 3'd0;
      acc_q      <= '0;
      phase_q    <= PH_BLANKS;
      neg_q      <= 1'b0;
      servo_q    <= '0;
      motor_q    <= '0;
      one_prog_q <= ONE_NONE;
      flags_q    <= '0;
      ack_q      <= 1'b0;
      ended_q    <= 1'b0;
    end else begin
      tok_idx_q  <= tok_idx_d;
      in_tok_q   <= in_tok_d;
      ack_prog_q <= ack_prog_d;
      acc_q      <= acc_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      servo_q    <= servo_d;
      motor_q    <= motor_d;
      one_prog_q <= one_prog_d;
      flags_q    <= flags_d;
      ack_q      <= ack_d;
      ended_q    <= ended_d;
    end
  end

endmodule

/* hdl/semicolon_command_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// semicolon_command_frame_parser_top
// Byte-stream parser for ';'-separated command frames of the form
// ACK;servo;motor;lights;control, one result per frame.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one frame byte per transaction, with
// frame_end_i marking the terminator position (its byte is ignored). Every
// transaction with frame_end_i set produces exactly one result transaction
// on the output channel; all other bytes produce none.
// Each byte is first captured in an input register, then decoded by the
// tokenizer, which updates the frame state and, on a frame end, loads the
// output register. A result passes through the input register and then
// the output register, and a pending result can hold it in the first.
// Throughput is one byte per cycle while in_stall_o is low; per-byte work
// is one compare tree and one multiply-by-ten add on the number accumulator.
// When the receiver holds out_stall_i high, the result stays in the output
// register; bytes that produce no result keep flowing, and only a second
// frame end stalls the input until the pending result is taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// frame state to the start of a frame.
// ----------------------------------------------------------------------------
module semicolon_command_frame_parser_top import scpf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_byte_i,
  input  logic                   frame_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic [VALUE_WIDTH-1:0] servo_command_o,
  output logic [VALUE_WIDTH-1:0] motor_command_o,
  output logic                   lights_on_o,
  output logic                   control_on_o
);

  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   s1_char_q;
  logic         s1_end_q;
  logic         out_valid_q, out_valid_d;
  scpf_result_t out_res_q;
  scpf_result_t core_res;
  logic         out_free;
  logic         s1_fire;
  logic         in_take;

  // The output slot is free when it is empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Only a frame end needs the output slot; other bytes always move on.
  assign s1_fire    = s1_valid_q && (!s1_end_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input payload register; loaded only on a transaction.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= char_byte_i;
      s1_end_q  <= frame_end_i;
    end
  end

  scpf_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .char_i   (s1_char_q),
    .end_i    (s1_end_q),
    .result_o (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_end_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_end_q) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_res_q.accepted;
  assign servo_command_o = out_res_q.servo;
  assign motor_command_o = out_res_q.motor;
  assign lights_on_o     = out_res_q.lights;
  assign control_on_o    = out_res_q.control;

  // A frame end that leaves the input register must present a result next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_end_q) |=> out_valid_q)
    else $error("frame end did not produce a result");

  // A pending result that is held back is never overwritten by a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(s1_fire && s1_end_q))
    else $error("pending result overwritten");

  // A rejected frame carries all-zero command fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |->
      (servo_command_o == '0 && motor_command_o == '0 && !lights_on_o && !control_on_o))
    else $error("rejected frame with nonzero fields");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the semicolon command frame parser. Frames of text
// are fed one byte per transaction, and an independent model of the frame
// grammar predicts the command result of every frame end. Each result that
// leaves the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench import scpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no transaction on either channel before the run is
  // declared hung. The longest legal quiet stretch is the long receiver hold.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Length of the deliberate receiver hold-off that backs up the input.
  localparam int unsigned LONG_HOLD      = 250;
  // The hold-off is requested once this many frames have gone in.
  localparam int unsigned HOLD_FRAME     = 12;
  // Stop generating frames once this many bytes and frames have been sent.
  localparam int unsigned ITEM_TARGET    = 900;
  localparam int unsigned MIN_FRAMES     = 40;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned DRAIN_CYCLES   = 10;
  // Mismatch lines beyond this count are counted but not printed.
  localparam int unsigned PRINT_CAP      = 50;

  // --------------------------------------------------------------------------
  // Scoreboard: a byte-level model of the parser plus the queue of commands
  // that the block still owes.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    scpf_result_t              owed_commands[$];
    int unsigned               mismatches;
    int unsigned               results_seen;

    string                     keyword = "ACK";
    logic [2:0]                tok_count;
    bit                        in_tok;
    logic [2:0]                ack_prog;
    longint unsigned           mag;
    logic [1:0]                phase;
    bit                        neg;
    logic [VALUE_WIDTH-1:0]    servo_hold;
    logic [VALUE_WIDTH-1:0]    motor_hold;
    logic [1:0]                one_prog;
    bit                        lights_hold;
    bit                        control_hold;
    bit                        ack_ok;
    bit                        text_done;

    function new();
      mismatches   = 0;
      results_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      tok_count    = TOK_NONE;
      in_tok       = 0;
      ack_prog     = '0;
      mag          = 0;
      phase        = PH_BLANKS;
      neg          = 0;
      servo_hold   = '0;
      motor_hold   = '0;
      one_prog     = ONE_NONE;
      lights_hold  = 0;
      control_hold = 0;
      ack_ok       = 0;
      text_done    = 0;
    endfunction

    // Signed value of the number token just scanned. A negative magnitude
    // can reach the most negative value; a positive one is clamped below it.
    function logic [VALUE_WIDTH-1:0] number_value();
      logic [63:0] m;
      m = mag;
      if (neg) begin
        m = 64'd0 - m;
      end else if (m > (64'd1 << (VALUE_WIDTH - 1)) - 1) begin
        m = (64'd1 << (VALUE_WIDTH - 1)) - 1;
      end
      return m[VALUE_WIDTH-1:0];
    endfunction

    function void close_token();
      case (tok_count)
        TOK_ACK:   ack_ok = (ack_prog == ACK_DONE);
        TOK_SERVO: servo_hold = number_value();
        TOK_MOTOR: motor_hold = number_value();
        TOK_LIGHT: if (one_prog == ONE_SEEN) lights_hold = 1;
        TOK_CTRL:  if (one_prog == ONE_SEEN) control_hold = 1;
        default: ;
      endcase
      in_tok = 0;
    endfunction

    // Advances the model by one accepted input transaction and, on a frame
    // end, queues the command the block has to produce.
    function void note_byte(logic [7:0] c, logic fe);
      scpf_result_t cmd;
      cmd = '0;
      if (fe) begin
        if (in_tok) close_token();
        if (ack_ok) begin
          cmd.accepted = 1'b1;
          cmd.servo    = servo_hold;
          cmd.motor    = motor_hold;
          cmd.lights   = lights_hold;
          cmd.control  = control_hold;
        end
        owed_commands.push_back(cmd);
        clear_frame();
        return;
      end
      if (text_done) return;
      if (c == CH_NUL) begin
        if (in_tok) close_token();
        text_done = 1;
        return;
      end
      if (c == CH_SEMI) begin
        if (in_tok) close_token();
        return;
      end
      if (!in_tok) begin
        in_tok = 1;
        if (tok_count < TOK_EXTRA) tok_count++;
        ack_prog = '0;
        mag      = 0;
        phase    = PH_BLANKS;
        neg      = 0;
        one_prog = ONE_NONE;
      end
      case (tok_count)
        TOK_ACK: begin
          if (ack_prog < ACK_DONE && c == keyword[int'(ack_prog)]) ack_prog++;
          else ack_prog = ACK_FAIL;
        end
        TOK_SERVO, TOK_MOTOR: begin
          if (phase == PH_BLANKS && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            // Leading white space is skipped.
          end else if (phase == PH_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
            neg   = (c == CH_MINUS);
            phase = PH_SIGNED;
          end else if (phase != PH_STOP && c >= CH_ZERO && c <= CH_NINE) begin
            mag = mag * 10 + (c - CH_ZERO);
            if (mag > (64'd1 << (VALUE_WIDTH - 1))) mag = 64'd1 << (VALUE_WIDTH - 1);
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOP;
          end
        end
        TOK_LIGHT, TOK_CTRL: begin
          if (one_prog == ONE_NONE && c == CH_ONE) one_prog = ONE_SEEN;
          else one_prog = ONE_FAIL;
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_CAP) begin
        $display("%0t: command %0d: %s got %0h, expected %0h",
                 $realtime, results_seen, what, got, want);
      end
      mismatches++;
    endtask

    task check_command(scpf_result_t got);
      scpf_result_t want;
      if (owed_commands.size() == 0) begin
        report("unexpected command", 32'(got.accepted), 32'd0);
      end else begin
        want = owed_commands.pop_front();
        if (got.accepted !== want.accepted)
          report("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.servo !== want.servo)
          report("servo_command", 32'(got.servo), 32'(want.servo));
        if (got.motor !== want.motor)
          report("motor_command", 32'(got.motor), 32'(want.motor));
        if (got.lights !== want.lights)
          report("lights_on", 32'(got.lights), 32'(want.lights));
        if (got.control !== want.control)
          report("control_on", 32'(got.control), 32'(want.control));
      end
      results_seen++;
    endtask

    function int unsigned pending();
      return owed_commands.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its channels. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             char_byte_i = 8'h00;
  logic                   frame_end_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   accepted_o;
  logic [VALUE_WIDTH-1:0] servo_command_o;
  logic [VALUE_WIDTH-1:0] motor_command_o;
  logic                   lights_on_o;
  logic                   control_on_o;
  scpf_result_t           seen_command;

  semicolon_command_frame_parser_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_byte_i     (char_byte_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .servo_command_o (servo_command_o),
    .motor_command_o (motor_command_o),
    .lights_on_o     (lights_on_o),
    .control_on_o    (control_on_o)
  );

  assign seen_command = {accepted_o, servo_command_o, motor_command_o,
                         lights_on_o, control_on_o};

  frame_scoreboard scoreboard;

  // Frame text under construction and stimulus bookkeeping.
  logic [7:0]  frame_text[$];
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  bit          send_quiet   = 0;
  bit          recv_quiet   = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  int unsigned stall_left   = 0;
  int unsigned recv_cycles  = 0;

  // Token texts that the random frames draw from.
  string       limit_texts[$]   = '{"32767", "32768", "-32768", "-32769", "0", "-0",
                                    "+32767", "65535", "-65536", "4294967296"};
  string       near_keywords[$] = '{"AC", "ACKK", "ack", "AK", "xACK", "ACK1", " ACK", "BCK"};
  string       flag_texts[$]    = '{"1", "1", "1", "1", "1", "1", "0", "11", "10", "x"};
  logic [7:0]  blank_chars[6]   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // The clock runs from time zero with a 12 ns period.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Most pauses are short, a few are long, and quiet stretches have none.
  function automatic int unsigned pick_pause(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) frame_text.push_back(s[i]);
  endtask

  // Offers one byte transaction and returns at the edge that accepts it.
  // Valid is only lowered when a gap is wanted, so back-to-back transactions
  // keep it high without a second assignment in the same time step.
  task automatic send_item(logic [7:0] c, logic fe);
    int unsigned gap;
    gap = pick_pause(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    frame_end_i <= fe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_byte(c, fe);
    bytes_sent++;
  endtask

  // Sends the prepared text followed by a frame end, whose byte is random
  // since the block has to ignore it.
  task automatic send_frame();
    foreach (frame_text[i]) send_item(frame_text[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    frame_text.delete();
    frames_sent++;
    // Once, well into the run, the receiver is asked to hold off for a long
    // time while bytes keep coming, so that the block backs up its input.
    if (frames_sent == HOLD_FRAME) holds_asked++;
  endtask

  // Builds one random frame. Most frames follow the command grammar with
  // random content: spare separators, blanks, signs, long digit runs, junk
  // after numbers, wrong keywords, missing or extra tokens. A few are pure
  // byte noise, and some get a zero byte or a corrupted byte dropped in.
  task automatic make_frame();
    int unsigned ntok;
    int unsigned n;
    int unsigned pos;
    frame_text.delete();
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(0, 24);
      repeat (n) frame_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ntok = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) frame_text.push_back(CH_SEMI);
    end
    for (int k = 1; k <= ntok; k++) begin
      if (k > 1) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) frame_text.push_back(CH_SEMI);
      end
      if (k == 1) begin
        if ($urandom_range(0, 99) < 88) append_text("ACK");
        else append_text(near_keywords[$urandom_range(0, near_keywords.size() - 1)]);
      end else if (k <= 3) begin
        if ($urandom_range(0, 99) < 12) begin
          append_text(limit_texts[$urandom_range(0, limit_texts.size() - 1)]);
        end else begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
          repeat (n) frame_text.push_back(blank_chars[$urandom_range(0, 5)]);
          case ($urandom_range(0, 3))
            0: frame_text.push_back(CH_PLUS);
            1: frame_text.push_back(CH_MINUS);
            default: ;
          endcase
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
          repeat (n) frame_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 7) == 0) begin
            frame_text.push_back(8'($urandom_range(8'h21, 8'h7E)));
            repeat ($urandom_range(0, 2)) frame_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
      end else begin
        append_text(flag_texts[$urandom_range(0, flag_texts.size() - 1)]);
      end
    end
    if ($urandom_range(0, 4) == 0) frame_text.push_back(CH_SEMI);
    if ($urandom_range(0, 19) == 0) begin
      pos = $urandom_range(0, frame_text.size());
      frame_text.insert(pos, CH_NUL);
    end
    if (frame_text.size() > 0 && $urandom_range(0, 14) == 0) begin
      pos = $urandom_range(0, frame_text.size() - 1);
      frame_text[pos] = 8'($urandom_range(0, 255));
    end
  endtask

  // Receiver: random stall patterns, occasional quiet windows with no
  // stall at all, and the one long hold-off when the sender asks for it.
  // Exactly one assignment to out_stall_i happens per clock edge.
  always @(posedge clk_i) begin
    recv_cycles++;
    if (recv_cycles % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end else begin
        stall_left = pick_pause(recv_quiet);
      end
    end
  end

  // Every result transaction is checked against the oldest owed command.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) scoreboard.check_command(seen_command);
  end

  // Watchdog: ends the run if no transaction happens on either channel for
  // too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence: reset, directed frames, random frames, drain, verdict.
  initial begin
    scoreboard = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty frame gives the not-accepted command.
    send_frame();
    // Both numbers overflow, in opposite directions, both flags are set, and
    // a sixth token must be ignored.
    append_text("ACK;-99999;77777;1;1;9");
    send_frame();
    // Blanks and a sign before a number with junk after it, then a zero
    // byte that ends the text, so the trailing flag never counts and the
    // missing motor token reads as zero.
    append_text("ACK; +7x");
    frame_text.push_back(CH_NUL);
    append_text(";1");
    send_frame();
    // A keyword that stops short is not accepted.
    append_text("AC");
    send_frame();

    while (bytes_sent < ITEM_TARGET || frames_sent < MIN_FRAMES) begin
      send_quiet = ($urandom_range(0, 4) == 0);
      make_frame();
      send_frame();
    end
    in_valid_i <= 1'b0;

    // Wait for every owed command, then a little longer in case the block
    // produces one it should not.
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (scoreboard.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/scpf_pkg.sv
hdl/scpf_core.sv
hdl/semicolon_command_frame_parser_top.sv
tb/testbench.sv
